/* design/clm_pkg.sv */
// Shared types and constants for the caching lock manager.
// Used by clm_decide, caching_lock_manager_core and the testbench; depends on nothing.
`timescale 1ns / 1ps

package clm_pkg;

    localparam int LOCK_W     = 6;
    localparam int CLIENT_W   = 4;
    localparam int LOCK_COUNT = 2 ** LOCK_W;
    // The waiter queue depth must be a power of two: slots wrap by truncation.
    localparam int WAIT_DEPTH = 8;
    localparam int HEAD_W     = $clog2(WAIT_DEPTH);
    localparam int CNT_W      = $clog2(WAIT_DEPTH + 1);
    localparam int FIFO_AW    = LOCK_W + HEAD_W;
    localparam int FIFO_DEPTH = LOCK_COUNT * WAIT_DEPTH;

    localparam logic       ACT_ACQUIRE = 1'b0;
    localparam logic       ACT_RELEASE = 1'b1;

    localparam logic [1:0] RS_OK    = 2'd0;
    localparam logic [1:0] RS_RETRY = 2'd1;
    localparam logic [1:0] RS_FULL  = 2'd2;

    localparam logic       NK_REVOKE = 1'b0;
    localparam logic       NK_RETRY  = 1'b1;

    typedef enum logic [1:0] {
        PH_FREE     = 2'd0,
        PH_HELD     = 2'd1,
        PH_REVOKING = 2'd2,
        PH_RETRYING = 2'd3
    } t_phase;

    typedef struct packed {
        logic                action;
        logic [LOCK_W-1:0]   lock_id;
        logic [CLIENT_W-1:0] client_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          reply_status;
        logic                notify_valid;
        logic                notify_kind;
        logic [CLIENT_W-1:0] notify_client;
        logic [LOCK_W-1:0]   notify_lock;
    } t_out_item;

    // Per-lock record; an all-zero record is a free lock with an empty queue.
    typedef struct packed {
        t_phase              phase;
        logic [CLIENT_W-1:0] holder;
        logic [HEAD_W-1:0]   head;
        logic [CNT_W-1:0]    count;
    } t_lock_rec;

    localparam int REC_W = $bits(t_lock_rec);

    typedef struct packed {
        t_lock_rec           next_rec;
        logic                push;
        logic [HEAD_W-1:0]   push_slot;
        logic                pop;
        t_out_item           result;
    } t_decision;

endpackage

/* design/caching_lock_manager_core.sv */
// Caching lock manager: lock table with revoke and retry notices.
// Depends on clm_pkg, clm_ram and clm_decide.
`timescale 1ns / 1ps

// The block takes one request per clock whenever busy is low, which is every
// cycle except the first one after reset. Each request produces exactly one
// result beat, marked by o_valid, registered through stage 1 and stage 2, in
// request order. The receiver cannot hold results off; none is ever dropped.
// The lock record memory is read in the accept cycle and the waiter queue in
// the following cycle; back-to-back requests to the same lock are forwarded
// around the lock record and retrier memories.
module caching_lock_manager_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  clm_pkg::t_in_item  i_item,
    output logic               o_valid,
    output clm_pkg::t_out_item o_result
);

    // Stage 1: request with its lock record.
    logic                            r_s1_vld;
    clm_pkg::t_in_item               r_s1_item;
    logic                            r_s1_rvld;
    logic                            r_s1_rec_hit;
    clm_pkg::t_lock_rec              r_s1_rec_byp;
    logic                            r_s1_ret_hit;
    logic [clm_pkg::CLIENT_W-1:0]    r_s1_ret_byp;

    // Stage 2: result, waiting only for the popped waiter.
    logic                            r_s2_vld;
    logic                            r_s2_pop;
    logic [clm_pkg::LOCK_W-1:0]      r_s2_lock;
    clm_pkg::t_out_item              r_s2_res;

    logic                            r_busy;
    logic [clm_pkg::LOCK_COUNT-1:0]  r_rec_vld;

    logic                            accept;
    logic [clm_pkg::REC_W-1:0]       rec_rdata;
    logic [clm_pkg::CLIENT_W-1:0]    ret_rdata;
    logic [clm_pkg::CLIENT_W-1:0]    fifo_rdata;
    clm_pkg::t_lock_rec              s1_rec;
    logic [clm_pkg::CLIENT_W-1:0]    s1_retrier;
    clm_pkg::t_decision              dec;
    logic                            s2_pop_same;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    clm_ram #(
        .WIDTH (clm_pkg::REC_W),
        .DEPTH (clm_pkg::LOCK_COUNT)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_item.lock_id),
        .i_wdata (dec.next_rec),
        .i_raddr (i_item.lock_id),
        .o_rdata (rec_rdata)
    );

    clm_ram #(
        .WIDTH (clm_pkg::CLIENT_W),
        .DEPTH (clm_pkg::LOCK_COUNT)
    ) u_ret_ram (
        .i_clk   (i_clk),
        .i_we    (r_s2_vld && r_s2_pop),
        .i_waddr (r_s2_lock),
        .i_wdata (fifo_rdata),
        .i_raddr (i_item.lock_id),
        .o_rdata (ret_rdata)
    );

    clm_ram #(
        .WIDTH (clm_pkg::CLIENT_W),
        .DEPTH (clm_pkg::FIFO_DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld && dec.push),
        .i_waddr ({r_s1_item.lock_id, dec.push_slot}),
        .i_wdata (r_s1_item.client_id),
        .i_raddr ({r_s1_item.lock_id, s1_rec.head}),
        .o_rdata (fifo_rdata)
    );

    // The newest copy of a record wins: the one written at the accept edge is
    // bypassed, a never-written record reads as a free lock.
    always_comb begin
        if (r_s1_rec_hit) begin
            s1_rec = r_s1_rec_byp;
        end else if (r_s1_rvld) begin
            s1_rec = clm_pkg::t_lock_rec'(rec_rdata);
        end else begin
            s1_rec = '0;
        end
    end

    assign s2_pop_same = r_s2_vld && r_s2_pop && (r_s2_lock == r_s1_item.lock_id);

    always_comb begin
        priority if (s2_pop_same) begin
            s1_retrier = fifo_rdata;
        end else if (r_s1_ret_hit) begin
            s1_retrier = r_s1_ret_byp;
        end else begin
            s1_retrier = ret_rdata;
        end
    end

    clm_decide u_decide (
        .i_item    (r_s1_item),
        .i_rec     (s1_rec),
        .i_retrier (s1_retrier),
        .o_dec     (dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_rec_vld <= '0;
        end else begin
            r_busy   <= 1'b0;
            r_s1_vld <= accept;
            r_s2_vld <= r_s1_vld;
            if (r_s1_vld) begin
                r_rec_vld[r_s1_item.lock_id] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item    <= i_item;
            r_s1_rvld    <= r_rec_vld[i_item.lock_id];
            r_s1_rec_hit <= r_s1_vld && (r_s1_item.lock_id == i_item.lock_id);
            r_s1_rec_byp <= dec.next_rec;
            r_s1_ret_hit <= r_s2_vld && r_s2_pop && (r_s2_lock == i_item.lock_id);
            r_s1_ret_byp <= fifo_rdata;
        end
        r_s2_pop  <= dec.pop;
        r_s2_lock <= r_s1_item.lock_id;
        r_s2_res  <= dec.result;
    end

    assign o_valid = r_s2_vld;

    always_comb begin
        o_result = r_s2_res;
        if (r_s2_pop) begin
            o_result.notify_client = fifo_rdata;
        end
    end

endmodule

/* design/clm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read during a write to the same address returns the old contents.
`timescale 1ns / 1ps

module clm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/clm_decide.sv */
// Next-state and reply logic for one request against one lock record.
// Depends on clm_pkg.
`timescale 1ns / 1ps

module clm_decide (
    input  clm_pkg::t_in_item                i_item,
    input  clm_pkg::t_lock_rec               i_rec,
    input  logic [clm_pkg::CLIENT_W-1:0]     i_retrier,
    output clm_pkg::t_decision               o_dec
);

    logic full;
    logic has_waiters;

    assign full        = (i_rec.count == clm_pkg::CNT_W'(clm_pkg::WAIT_DEPTH));
    assign has_waiters = (i_rec.count != '0);

    always_comb begin
        o_dec                      = '0;
        o_dec.next_rec             = i_rec;
        o_dec.push_slot            = clm_pkg::HEAD_W'(i_rec.head + i_rec.count);
        o_dec.result.reply_status  = clm_pkg::RS_OK;

        if (i_item.action == clm_pkg::ACT_ACQUIRE) begin
            unique case (i_rec.phase)
                clm_pkg::PH_FREE: begin
                    o_dec.next_rec.holder = i_item.client_id;
                    o_dec.next_rec.phase  = clm_pkg::PH_HELD;
                end
                clm_pkg::PH_HELD: begin
                    if (full) begin
                        o_dec.result.reply_status = clm_pkg::RS_FULL;
                    end else begin
                        o_dec.push                 = 1'b1;
                        o_dec.next_rec.phase       = clm_pkg::PH_REVOKING;
                        o_dec.result.reply_status  = clm_pkg::RS_RETRY;
                        o_dec.result.notify_valid  = 1'b1;
                        o_dec.result.notify_kind   = clm_pkg::NK_REVOKE;
                        o_dec.result.notify_client = i_rec.holder;
                    end
                end
                clm_pkg::PH_REVOKING: begin
                    if (full) begin
                        o_dec.result.reply_status = clm_pkg::RS_FULL;
                    end else begin
                        o_dec.push                = 1'b1;
                        o_dec.result.reply_status = clm_pkg::RS_RETRY;
                    end
                end
                clm_pkg::PH_RETRYING: begin
                    if (i_item.client_id == i_retrier) begin
                        o_dec.next_rec.holder = i_item.client_id;
                        if (has_waiters) begin
                            // Others are still queued, so the new holder is
                            // asked to give the lock back right away.
                            o_dec.next_rec.phase       = clm_pkg::PH_REVOKING;
                            o_dec.result.notify_valid  = 1'b1;
                            o_dec.result.notify_kind   = clm_pkg::NK_REVOKE;
                            o_dec.result.notify_client = i_item.client_id;
                        end else begin
                            o_dec.next_rec.phase = clm_pkg::PH_HELD;
                        end
                    end else if (full) begin
                        o_dec.result.reply_status = clm_pkg::RS_FULL;
                    end else begin
                        o_dec.push                = 1'b1;
                        o_dec.result.reply_status = clm_pkg::RS_RETRY;
                    end
                end
                default: begin
                    o_dec.next_rec = i_rec;
                end
            endcase
        end else if (i_rec.phase != clm_pkg::PH_FREE) begin
            o_dec.next_rec.holder = '0;
            if (has_waiters) begin
                // The popped client arrives from the queue memory in the next cycle.
                o_dec.pop                 = 1'b1;
                o_dec.next_rec.head       = i_rec.head + clm_pkg::HEAD_W'(1);
                o_dec.next_rec.count      = i_rec.count - clm_pkg::CNT_W'(1);
                o_dec.next_rec.phase      = clm_pkg::PH_RETRYING;
                o_dec.result.notify_valid = 1'b1;
                o_dec.result.notify_kind  = clm_pkg::NK_RETRY;
            end else begin
                o_dec.next_rec.phase = clm_pkg::PH_FREE;
            end
        end

        if (o_dec.push) begin
            o_dec.next_rec.count = i_rec.count + clm_pkg::CNT_W'(1);
        end

        if (o_dec.result.notify_valid) begin
            o_dec.result.notify_lock = i_item.lock_id;
        end
    end

endmodule

/* test/tb.sv */
// Self-checking testbench for caching_lock_manager_core: directed and random lock requests.
// Depends on clm_pkg and the lock manager RTL. Expected replies come from a lock table model.
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_ITEMS = 1800;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int EXP_DEPTH    = 16;

    // Lock table model: tracks every lock and queues the reply that each request causes.
    class lock_table_model;
        clm_pkg::t_phase              phase   [clm_pkg::LOCK_COUNT];
        logic [clm_pkg::CLIENT_W-1:0] holder  [clm_pkg::LOCK_COUNT];
        logic [clm_pkg::CLIENT_W-1:0] retrier [clm_pkg::LOCK_COUNT];
        logic [clm_pkg::CLIENT_W-1:0] waiters [clm_pkg::LOCK_COUNT][clm_pkg::WAIT_DEPTH];
        logic [clm_pkg::HEAD_W-1:0]   head    [clm_pkg::LOCK_COUNT];
        logic [clm_pkg::CNT_W-1:0]    count   [clm_pkg::LOCK_COUNT];
        clm_pkg::t_out_item           exp_ring [EXP_DEPTH];
        int                           exp_wr;
        int                           exp_rd;
        int                           exp_cnt;
        int                           failures;

        function new();
            failures = 0;
            exp_wr   = 0;
            exp_rd   = 0;
            exp_cnt  = 0;
            for (int k = 0; k < clm_pkg::LOCK_COUNT; k++) begin
                phase[k]   = clm_pkg::PH_FREE;
                holder[k]  = '0;
                retrier[k] = '0;
                head[k]    = '0;
                count[k]   = '0;
            end
        endfunction

        function bit push_waiter(logic [clm_pkg::LOCK_W-1:0] lk,
                                 logic [clm_pkg::CLIENT_W-1:0] who);
            logic [clm_pkg::HEAD_W-1:0] slot;
            if (count[lk] >= clm_pkg::WAIT_DEPTH)
                return 1'b0;
            slot = head[lk] + count[lk][clm_pkg::HEAD_W-1:0];
            waiters[lk][slot] = who;
            count[lk]++;
            return 1'b1;
        endfunction

        function logic [clm_pkg::CLIENT_W-1:0] pop_waiter(logic [clm_pkg::LOCK_W-1:0] lk);
            logic [clm_pkg::CLIENT_W-1:0] who;
            who = waiters[lk][head[lk]];
            head[lk]++;
            count[lk]--;
            return who;
        endfunction

        // Applies one accepted request to the table and queues its reply.
        function void note_request(clm_pkg::t_in_item req);
            clm_pkg::t_out_item           r;
            logic [clm_pkg::LOCK_W-1:0]   lk;
            logic [clm_pkg::CLIENT_W-1:0] who;
            r   = '0;
            lk  = req.lock_id;
            who = req.client_id;
            r.reply_status = clm_pkg::RS_OK;
            if (req.action == clm_pkg::ACT_ACQUIRE) begin
                case (phase[lk])
                    clm_pkg::PH_FREE: begin
                        holder[lk] = who;
                        phase[lk]  = clm_pkg::PH_HELD;
                    end
                    clm_pkg::PH_HELD: begin
                        if (push_waiter(lk, who)) begin
                            phase[lk]       = clm_pkg::PH_REVOKING;
                            r.reply_status  = clm_pkg::RS_RETRY;
                            r.notify_valid  = 1'b1;
                            r.notify_kind   = clm_pkg::NK_REVOKE;
                            r.notify_client = holder[lk];
                        end else begin
                            r.reply_status = clm_pkg::RS_FULL;
                        end
                    end
                    clm_pkg::PH_REVOKING: begin
                        r.reply_status = push_waiter(lk, who) ? clm_pkg::RS_RETRY
                                                              : clm_pkg::RS_FULL;
                    end
                    default: begin
                        if (who == retrier[lk]) begin
                            holder[lk]  = who;
                            retrier[lk] = '0;
                            // The new holder is asked to give the lock back at once
                            // when others are still waiting.
                            if (count[lk] != 0) begin
                                phase[lk]       = clm_pkg::PH_REVOKING;
                                r.notify_valid  = 1'b1;
                                r.notify_kind   = clm_pkg::NK_REVOKE;
                                r.notify_client = who;
                            end else begin
                                phase[lk] = clm_pkg::PH_HELD;
                            end
                        end else begin
                            r.reply_status = push_waiter(lk, who) ? clm_pkg::RS_RETRY
                                                                  : clm_pkg::RS_FULL;
                        end
                    end
                endcase
            end else if (phase[lk] != clm_pkg::PH_FREE) begin
                holder[lk] = '0;
                if (count[lk] != 0) begin
                    retrier[lk]     = pop_waiter(lk);
                    phase[lk]       = clm_pkg::PH_RETRYING;
                    r.notify_valid  = 1'b1;
                    r.notify_kind   = clm_pkg::NK_RETRY;
                    r.notify_client = retrier[lk];
                end else begin
                    phase[lk] = clm_pkg::PH_FREE;
                end
            end
            if (r.notify_valid)
                r.notify_lock = lk;
            exp_ring[exp_wr] = r;
            exp_wr  = (exp_wr + 1) % EXP_DEPTH;
            exp_cnt++;
        endfunction

        function void check_result(clm_pkg::t_out_item got);
            clm_pkg::t_out_item exp_r;
            if (exp_cnt == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result beat: status=%0d nv=%0d kind=%0d ",
                             got.reply_status, got.notify_valid, got.notify_kind,
                             "client=%0d lock=%0d", got.notify_client, got.notify_lock);
                return;
            end
            exp_r   = exp_ring[exp_rd];
            exp_rd  = (exp_rd + 1) % EXP_DEPTH;
            exp_cnt--;
            if (got.reply_status !== exp_r.reply_status ||
                got.notify_valid !== exp_r.notify_valid ||
                got.notify_kind !== exp_r.notify_kind ||
                got.notify_client !== exp_r.notify_client ||
                got.notify_lock !== exp_r.notify_lock) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: expected status=%0d nv=%0d kind=%0d ",
                             exp_r.reply_status, exp_r.notify_valid, exp_r.notify_kind,
                             "client=%0d lock=%0d, ", exp_r.notify_client, exp_r.notify_lock,
                             "got status=%0d nv=%0d kind=%0d ",
                             got.reply_status, got.notify_valid, got.notify_kind,
                             "client=%0d lock=%0d", got.notify_client, got.notify_lock);
            end
        endfunction

        function int pending();
            return exp_cnt;
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    clm_pkg::t_in_item  i_item;
    logic               o_valid;
    clm_pkg::t_out_item o_result;

    lock_table_model model;
    logic [clm_pkg::LOCK_W-1:0] hot_locks [4];
    int idle_cycles;

    caching_lock_manager_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Results are checked before the request of the same edge is noted, since a
    // result always belongs to an earlier request.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                model.check_result(o_result);
            if (start && !busy)
                model.note_request(i_item);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int pick_gap(bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Most requests go to a few hot locks so that queues fill and drain; a waiting
    // retrier usually comes back for its lock.
    function automatic clm_pkg::t_in_item pick_request();
        clm_pkg::t_in_item req;
        logic [clm_pkg::LOCK_W-1:0] lk;
        if ($urandom_range(0, 99) < 80)
            lk = hot_locks[$urandom_range(0, 3)];
        else
            lk = clm_pkg::LOCK_W'($urandom_range(0, clm_pkg::LOCK_COUNT - 1));
        req.lock_id = lk;
        if (model.phase[lk] == clm_pkg::PH_RETRYING && $urandom_range(0, 99) < 55) begin
            req.action    = clm_pkg::ACT_ACQUIRE;
            req.client_id = model.retrier[lk];
        end else begin
            req.action    = ($urandom_range(0, 99) < 35) ? clm_pkg::ACT_RELEASE
                                                         : clm_pkg::ACT_ACQUIRE;
            req.client_id = clm_pkg::CLIENT_W'($urandom_range(0, 15));
        end
        return req;
    endfunction

    // Called at a falling edge; returns when the request is taken and any gap has passed.
    task automatic issue(input clm_pkg::t_in_item req, input int gap);
        start  <= 1'b1;
        i_item <= req;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (gap > 0) begin
            @(negedge i_clk);
            start  <= 1'b0;
            i_item <= $bits(clm_pkg::t_in_item)'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic directed(input logic act, input int lk, input int who);
        clm_pkg::t_in_item req;
        req.action    = act;
        req.lock_id   = clm_pkg::LOCK_W'(lk);
        req.client_id = clm_pkg::CLIENT_W'(who);
        @(negedge i_clk);
        issue(req, pick_gap(1'b0));
    endtask

    initial begin
        bit burst;
        model   = new();
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Revoke, retry hand-over and a final release on lock 0.
        directed(clm_pkg::ACT_ACQUIRE, 0, 0);
        directed(clm_pkg::ACT_ACQUIRE, 0, 15);
        directed(clm_pkg::ACT_ACQUIRE, 0, 5);
        directed(clm_pkg::ACT_RELEASE, 0, 9);
        directed(clm_pkg::ACT_ACQUIRE, 0, 15);
        directed(clm_pkg::ACT_RELEASE, 0, 15);
        directed(clm_pkg::ACT_ACQUIRE, 0, 5);
        directed(clm_pkg::ACT_RELEASE, 0, 5);
        // Releasing a free lock changes nothing.
        directed(clm_pkg::ACT_RELEASE, 10, 3);
        // Fill the waiter queue of lock 63, overflow it while revoking and retrying.
        directed(clm_pkg::ACT_ACQUIRE, 63, 1);
        for (int c = 2; c <= 9; c++)
            directed(clm_pkg::ACT_ACQUIRE, 63, c);
        directed(clm_pkg::ACT_ACQUIRE, 63, 10);
        directed(clm_pkg::ACT_RELEASE, 63, 1);
        directed(clm_pkg::ACT_ACQUIRE, 63, 11);
        directed(clm_pkg::ACT_ACQUIRE, 63, 12);
        directed(clm_pkg::ACT_ACQUIRE, 63, 2);

        burst = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 150 == 0)
                for (int k = 0; k < 4; k++)
                    hot_locks[k] = clm_pkg::LOCK_W'($urandom_range(0, clm_pkg::LOCK_COUNT - 1));
            if (i % 100 == 0)
                burst = ($urandom_range(0, 2) == 0);
            @(negedge i_clk);
            issue(pick_request(), pick_gap(burst));
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (model.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (model.failures == 0 && model.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
design/clm_pkg.sv
design/clm_ram.sv
design/clm_decide.sv
design/caching_lock_manager_core.sv
test/tb.sv
